>>> rtl/cic_pkg.sv
// Package for the cascaded interrupt controller: types and codes for the
// controller and the datapath, and the priority resolver functions of the datapath.
// No dependencies.
package cic_pkg;

   typedef enum logic [2:0] {
      CMD_PORT_WR  = 3'd0,
      CMD_PORT_RD  = 3'd1,
      CMD_LINE     = 3'd2,
      CMD_ACK      = 3'd3,
      CMD_ELCR_WR  = 3'd4,
      CMD_ELCR_RD  = 3'd5,
      CMD_UNUSED6  = 3'd6,
      CMD_UNUSED7  = 3'd7
   } cmd_type;

   localparam logic       CFG_ALLOW_MASTER = 1'b0;
   localparam logic       CFG_ALLOW_SLAVE  = 1'b1;
   localparam logic [7:0] ALLOW_MASTER_RST = 8'hf8;
   localparam logic [7:0] ALLOW_SLAVE_RST  = 8'hde;
   localparam logic [7:0] POLL_HIT         = 8'h80;
   localparam logic [7:0] POLL_NONE        = 8'h07;

   // Controller to datapath commands.
   typedef struct packed {
      logic    exec;
      logic    ack2;
      cmd_type cmd;
   } ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      logic m_is2;
   } sts_type;

   typedef struct packed {
      logic [7:0] edge_seen;
      logic [7:0] irr;
      logic [7:0] imr;
      logic [7:0] isr;
      logic [2:0] pbase;
      logic [4:0] vbase;
      logic       rd_isr;
      logic       poll;
      logic       smm;
      logic [1:0] init_step;
      logic       aeoi;
      logic       rot_aeoi;
      logic       sfnm;
      logic       icw4;
      logic       single;
      logic       ltim;
      logic [7:0] elcr;
   } chip_type;

   // Priority rank of mask m under rotation base b; 8 means none.
   function automatic logic [3:0] prio_of(input logic [7:0] m, input logic [2:0] b);
      logic [3:0] r;
      logic [2:0] idx;
      r = 4'd8;
      for (int p = 7; p >= 0; p--) begin
         idx = 3'(p) + b;
         if (m[idx]) r = 4'(p);
      end
      return r;
   endfunction

   // Best deliverable line: {valid, line}.
   function automatic logic [3:0] best_line(input chip_type s, input logic is_master);
      logic [3:0] p;
      logic [3:0] q;
      logic [7:0] cur;
      p   = prio_of(s.irr & ~s.imr, s.pbase);
      cur = s.isr;
      if (s.smm) cur = cur & ~s.imr;
      if (s.sfnm && is_master) cur[2] = 1'b0;
      q   = prio_of(cur, s.pbase);
      if (!p[3] && p < q) return {1'b1, p[2:0] + s.pbase};
      return 4'd0;
   endfunction

endpackage

>>> rtl/cic_ctrl.sv
// Controller for the cascaded interrupt controller: sequences each
// transaction, passing through ST_ACK2 for an acknowledge through the slave.
// Depends on cic_pkg.
module cic_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_start,
   input  cic_pkg::cmd_type req_cmd,
   input  cic_pkg::sts_type sts,
   output logic             req_busy,
   output cic_pkg::ctl_type ctl,
   output logic             rsp_valid
);

   typedef enum logic [1:0] {ST_IDLE, ST_ACK2} state_type;

   state_type state_ff;
   logic      valid_ff;
   logic      take;

   assign req_busy  = (state_ff != ST_IDLE);
   assign take      = req_start && !req_busy;
   assign rsp_valid = valid_ff;

   always_comb begin
      ctl.exec = take;
      ctl.cmd  = req_cmd;
      ctl.ack2 = (state_ff == ST_ACK2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  if (req_cmd == cic_pkg::CMD_ACK && sts.m_is2) state_ff <= ST_ACK2;
                  else valid_ff <= 1'b1;
               end
            end
            ST_ACK2: begin
               state_ff <= ST_IDLE;
               valid_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/cic_dp.sv
// Datapath for the cascaded interrupt controller: per-chip register files,
// port decode, line events, acknowledge and cascade repair.
// Depends on cic_pkg.
module cic_dp (
   input  logic             clock,
   input  logic             reset,
   input  cic_pkg::ctl_type ctl,
   input  logic             req_chip,
   input  logic             req_port,
   input  logic [7:0]       req_wdata,
   input  logic [3:0]       req_line,
   input  logic             req_line_level,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata,
   output cic_pkg::sts_type sts,
   output logic [7:0]       rsp_rdata,
   output logic [7:0]       rsp_vector,
   output logic             rsp_intr_active,
   output logic [2:0]       rsp_intr_line
);

   cic_pkg::chip_type chip_ff [2];
   cic_pkg::chip_type chip_in [2];
   logic [7:0] allow_m_ff, allow_s_ff;
   logic [7:0] rdata_ff, rdata_in, vector_ff, vector_in;
   logic       ia_ff, ia_in;
   logic [2:0] il_ff, il_in;
   logic [3:0] m_best, s_best, pre_s;
   cic_pkg::chip_type pm;

   assign rsp_rdata       = rdata_ff;
   assign rsp_vector      = vector_ff;
   assign rsp_intr_active = ia_ff;
   assign rsp_intr_line   = il_ff;

   // master after pre-ack refresh, used to pick the line at ack
   always_comb begin
      pm    = chip_ff[0];
      pre_s = cic_pkg::best_line(chip_ff[1], 1'b0);
      if (pre_s[3]) begin
         pm.edge_seen[2] = 1'b1;
         pm.irr[2]       = 1'b1;
      end else begin
         pm.edge_seen[2] = 1'b0;
      end
      m_best = cic_pkg::best_line(pm, 1'b1);
      s_best = cic_pkg::best_line(chip_ff[1], 1'b0);
      sts.m_is2 = m_best[3] && (m_best[2:0] == 3'd2);
   end

   always_comb begin
      cic_pkg::chip_type s;
      logic [3:0] p, r, fin_s, fin_m;
      logic [2:0] ln;
      logic [7:0] msk, allow, v, lm;
      logic       c;
      chip_in[0] = chip_ff[0];
      chip_in[1] = chip_ff[1];
      rdata_in   = 8'd0;
      vector_in  = 8'd0;
      c = req_chip;
      s = chip_ff[c];
      v = req_wdata;
      if (ctl.ack2) begin
         s = chip_ff[1];
         ln = 3'd7;
         if (s_best[3]) begin
            ln = s_best[2:0];
            if (s.aeoi) begin
               if (s.rot_aeoi) s.pbase = ln + 3'd1;
            end else s.isr[ln] = 1'b1;
            s.irr[ln] = 1'b0;
         end
         chip_in[1] = s;
         // master line 2 was taken when the acknowledge was issued; only the slave may raise it again
         chip_in[0].irr[2] = 1'b0;
         vector_in  = {chip_ff[1].vbase, ln};
      end else if (ctl.exec) begin
         unique case (ctl.cmd)
            cic_pkg::CMD_PORT_WR: begin
               if (!req_port) begin
                  if (v[4]) begin
                     s = '0;
                     s.init_step = 2'd1;
                     s.icw4   = v[0];
                     s.single = v[1];
                     s.ltim   = v[3];
                  end else if (v[3]) begin
                     if (v[2]) s.poll = 1'b1;
                     if (v[1]) s.rd_isr = v[0];
                     if (v[6]) s.smm = v[5];
                  end else begin
                     ln = v[2:0];
                     unique case (v[7:5])
                        3'd0, 3'd4: s.rot_aeoi = v[7];
                        3'd1, 3'd5: begin
                           p = cic_pkg::prio_of(s.isr, s.pbase);
                           if (!p[3]) begin
                              ln = p[2:0] + s.pbase;
                              s.isr[ln] = 1'b0;
                              if (v[7]) s.pbase = ln + 3'd1;
                           end
                        end
                        3'd3: s.isr[ln] = 1'b0;
                        3'd6: s.pbase = ln + 3'd1;
                        3'd7: begin
                           s.isr[ln] = 1'b0;
                           s.pbase   = ln + 3'd1;
                        end
                        default: ;
                     endcase
                  end
               end else begin
                  unique case (s.init_step)
                     2'd0: s.imr = v;
                     2'd1: begin
                        s.vbase = v[7:3];
                        s.init_step = s.single ? (s.icw4 ? 2'd3 : 2'd0) : 2'd2;
                     end
                     2'd2: s.init_step = s.icw4 ? 2'd3 : 2'd0;
                     default: begin
                        s.sfnm = v[4];
                        s.aeoi = v[1];
                        s.init_step = 2'd0;
                     end
                  endcase
               end
               chip_in[c] = s;
            end
            cic_pkg::CMD_PORT_RD: begin
               if (s.poll) begin
                  r = cic_pkg::best_line(s, !c);
                  s.poll = 1'b0;
                  if (r[3]) begin
                     s.irr[r[2:0]] = 1'b0;
                     s.isr[r[2:0]] = 1'b0;
                     rdata_in = cic_pkg::POLL_HIT | {5'd0, r[2:0]};
                  end else rdata_in = cic_pkg::POLL_NONE;
               end else if (!req_port) rdata_in = s.rd_isr ? s.isr : s.irr;
               else rdata_in = s.imr;
               chip_in[c] = s;
            end
            cic_pkg::CMD_LINE: begin
               c = req_line[3];
               s = chip_ff[c];
               msk = 8'd1 << req_line[2:0];
               allow = c ? allow_s_ff : allow_m_ff;
               lm = ((s.elcr & allow) | {8{s.ltim}}) & msk;
               if (lm != 8'd0) begin
                  if (req_line_level) s.irr = s.irr | msk;
                  else s.irr = s.irr & ~msk;
                  s.edge_seen = (s.edge_seen & ~msk) | (req_line_level ? msk : 8'd0);
               end else if (req_line_level) begin
                  if ((s.edge_seen & msk) == 8'd0) s.irr = s.irr | msk;
                  s.edge_seen = s.edge_seen | msk;
               end else s.edge_seen = s.edge_seen & ~msk;
               chip_in[c] = s;
            end
            cic_pkg::CMD_ACK: begin
               s = pm;
               if (!m_best[3]) vector_in = {s.vbase, 3'd7};
               else begin
                  ln = m_best[2:0];
                  if (s.aeoi) begin
                     if (s.rot_aeoi) s.pbase = ln + 3'd1;
                  end else s.isr[ln] = 1'b1;
                  s.irr[ln] = 1'b0;
                  vector_in = {s.vbase, ln};
               end
               chip_in[0] = s;
            end
            cic_pkg::CMD_ELCR_WR: begin
               s.elcr = v & (c ? allow_s_ff : allow_m_ff);
               chip_in[c] = s;
            end
            cic_pkg::CMD_ELCR_RD: rdata_in = s.elcr;
            default: ;
         endcase
      end
      // cascade repair and cpu line
      fin_s = cic_pkg::best_line(chip_in[1], 1'b0);
      if (fin_s[3]) begin
         chip_in[0].edge_seen[2] = 1'b1;
         chip_in[0].irr[2]       = 1'b1;
      end else chip_in[0].edge_seen[2] = 1'b0;
      fin_m = cic_pkg::best_line(chip_in[0], 1'b1);
      ia_in = fin_m[3];
      il_in = fin_m[3] ? fin_m[2:0] : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff[0] <= '0;
         chip_ff[1] <= '0;
         allow_m_ff <= cic_pkg::ALLOW_MASTER_RST;
         allow_s_ff <= cic_pkg::ALLOW_SLAVE_RST;
      end else begin
         if ((ctl.exec && !(ctl.cmd == cic_pkg::CMD_ACK && sts.m_is2)) || ctl.ack2
             || (ctl.exec && ctl.cmd == cic_pkg::CMD_ACK)) begin
            chip_ff[0] <= chip_in[0];
            chip_ff[1] <= chip_in[1];
         end
         if (csr_we && csr_index == cic_pkg::CFG_ALLOW_MASTER) allow_m_ff <= csr_wdata;
         if (csr_we && csr_index == cic_pkg::CFG_ALLOW_SLAVE)  allow_s_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctl.exec && !(ctl.cmd == cic_pkg::CMD_ACK && sts.m_is2)) || ctl.ack2) begin
         rdata_ff  <= rdata_in;
         vector_ff <= vector_in;
         ia_ff     <= ia_in;
         il_ff     <= il_in;
      end
   end

endmodule

>>> rtl/cascaded_interrupt_controller.sv
// Top level of the cascaded interrupt controller pair.
// Depends on cic_pkg, cic_ctrl and cic_dp.
//
// Usage: a transaction is issued by raising start while busy is low,
// with req_cmd selecting port write/read, line level, acknowledge or edge/
// level register write/read. Exactly one response follows: rsp_valid is high
// for one cycle with rsp_rdata, rsp_vector and the CPU line state
// (rsp_intr_active, rsp_intr_line) after the transaction.
// A response is registered and shown in the cycle after its transaction
// is taken, except an acknowledge that resolves to master line 2, which
// walks the slave in the ST_ACK2 state and answers after it. Throughput is
// one transaction per cycle otherwise; busy is high while ST_ACK2 walks the slave.
// The receiver cannot stall; responses must be taken when shown.
// csr_we/csr_index/csr_wdata write the level-allow registers, index 0 the
// master and 1 the slave, taken at once with no read-back.
// Synchronous reset clears both chips and sets the allow registers to their
// defaults; no clearing pass is needed.
module cascaded_interrupt_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic       req_chip,
   input  logic       req_port,
   input  logic [7:0] req_wdata,
   input  logic [3:0] req_line,
   input  logic       req_line_level,
   output logic       rsp_valid,
   output logic [7:0] rsp_rdata,
   output logic [7:0] rsp_vector,
   output logic       rsp_intr_active,
   output logic [2:0] rsp_intr_line,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   cic_pkg::ctl_type ctl;
   cic_pkg::sts_type sts;

   cic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (start),
      .req_cmd   (cic_pkg::cmd_type'(req_cmd)),
      .sts       (sts),
      .req_busy  (busy),
      .ctl       (ctl),
      .rsp_valid (rsp_valid)
   );

   cic_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_chip        (req_chip),
      .req_port        (req_port),
      .req_wdata       (req_wdata),
      .req_line        (req_line),
      .req_line_level  (req_line_level),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .sts             (sts),
      .rsp_rdata       (rsp_rdata),
      .rsp_vector      (rsp_vector),
      .rsp_intr_active (rsp_intr_active),
      .rsp_intr_line   (rsp_intr_line)
   );

endmodule
